// File: rtl/core/crc_pkg.sv
// Shared types and constants for the CRC generate/check core.
// No dependencies; imported by every module of the core.
`default_nettype none

package crc_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int DEG_W      = 6;
  localparam int REM_W      = 32;
  localparam int SEL_W      = $clog2(MAX_DEGREE);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Depth of the item queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 2'd1;

  localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd8;
  localparam logic [REM_W-1:0] POLY_RESET   = 32'd7;

  // One classified bit on its way to the divider
  typedef struct packed {
    logic data_bit;
    logic check;
    logic last;
  } item_t;

  // Divider setup derived from the configuration registers
  typedef struct packed {
    logic [SEL_W-1:0] top_sel;
    logic [REM_W-1:0] mask;
    logic [REM_W-1:0] gen;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/crc_front.sv
// Input stage: accepts items and classifies them for the item queue.
// Depends on crc_pkg.
`default_nettype none

module crc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic          data_bit,
  input  wire logic          mode,
  input  wire logic          last_bit,
  input  wire logic          q_full,
  output logic               q_push,
  output crc_pkg::item_t     q_item,
  output logic               front_valid
);
  import crc_pkg::*;

  logic  stage_valid;
  item_t stage_item;
  logic  accept;

  assign full   = stage_valid && q_full;
  assign accept = push && !full;
  assign q_push = stage_valid && !q_full;
  assign q_item = stage_item;
  assign front_valid = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.data_bit <= data_bit;
      stage_item.check    <= mode;
      stage_item.last     <= last_bit;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc_queue.sv
// Short item queue between the front and back stages.
// Depends on crc_pkg.
`default_nettype none

module crc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire crc_pkg::item_t    push_item,
  input  wire logic              pop,
  output crc_pkg::item_t         head,
  output crc_pkg::q_status_t     status
);
  import crc_pkg::*;

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc_back.sv
// Back stage: shift-and-XOR divider and the result register.
// Depends on crc_pkg.
`default_nettype none

module crc_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire crc_pkg::cfg_t             cfg,
  input  wire crc_pkg::item_t            head,
  input  wire logic                      q_empty,
  output logic                           take,
  input  wire logic                      pop,
  output logic                           empty,
  output logic [crc_pkg::REM_W-1:0]      remainder,
  output logic                           crc_error
);
  import crc_pkg::*;

  logic [REM_W-1:0] shift_rem;
  logic [REM_W-1:0] rem_cur;
  logic [REM_W-1:0] rem_next;
  logic             top;
  logic             feedback;
  logic             out_valid;

  // Non-last bits never need the result register
  assign take  = !q_empty && (!head.last || !out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    rem_cur = shift_rem & cfg.mask;
    top     = rem_cur[cfg.top_sel];
    if (head.check) begin
      feedback = top;
      rem_next = ((rem_cur << 1) | REM_W'(head.data_bit)) & cfg.mask;
    end else begin
      feedback = top ^ head.data_bit;
      rem_next = (rem_cur << 1) & cfg.mask;
    end
    if (feedback) begin
      rem_next = rem_next ^ cfg.gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_rem <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        // clear the divider once the codeword ends
        shift_rem <= head.last ? '0 : rem_next;
      end
      if (take && head.last) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && head.last) begin
      remainder <= rem_next;
      crc_error <= head.check && (rem_next != '0);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc_generate_and_check_core.sv
// CRC generate/check core: front stage, item queue, divider back stage.
// Path of a last bit: front stage register, queue, divider, result register.
// Throughput: one bit per cycle (shift-and-XOR divider) unless a result is held.
// Reset (rst, synchronous): queue and result empty, divider remainder zero,
// degree 8, poly 7.
// Depends on crc_pkg, crc_front, crc_queue, crc_back.
`default_nettype none

module crc_generate_and_check_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           data_bit,
  input  wire logic                           mode,
  input  wire logic                           last_bit,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [crc_pkg::REM_W-1:0]           remainder,
  output logic                                crc_error,
  input  wire logic                           cfg_we,
  input  wire logic [crc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [crc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crc_pkg::*;

  logic [DEG_W-1:0] degree;
  logic [REM_W-1:0] poly;
  logic [DEG_W-1:0] deg_eff;
  logic [DEG_W-1:0] deg_m1;
  cfg_t             cfg;

  item_t     q_item;
  item_t     head;
  q_status_t q_status;
  logic      q_push;
  logic      take;
  logic      front_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_RESET;
      poly   <= POLY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEGREE: degree <= cfg_data[DEG_W-1:0];
        CFG_POLY:   poly   <= cfg_data[REM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp degree to 1..MAX_DEGREE
  always_comb begin
    if (degree == '0) begin
      deg_eff = DEG_W'(1);
    end else if (degree > DEG_W'(MAX_DEGREE)) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = degree;
    end
    deg_m1      = deg_eff - 1'b1;
    cfg.top_sel = deg_m1[SEL_W-1:0];
    cfg.mask    = {REM_W{1'b1}} >> (DEG_W'(REM_W - 1) - deg_m1);
    cfg.gen     = poly & cfg.mask;
  end

  crc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_bit    (data_bit),
    .mode        (mode),
    .last_bit    (last_bit),
    .q_full      (q_status.full),
    .q_push      (q_push),
    .q_item      (q_item),
    .front_valid (front_valid)
  );

  crc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (take),
    .head      (head),
    .status    (q_status)
  );

  crc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_status.empty),
    .take      (take),
    .pop       (pop),
    .empty     (empty),
    .remainder (remainder),
    .crc_error (crc_error)
  );

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> !q_status.empty)
    else $error("divider took an item from an empty queue");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (take && head.last) |=> !empty)
    else $error("last bit taken but no result waiting");

  a_full_means_held: assert property (@(posedge clk) disable iff (rst)
    full |-> (front_valid && q_status.full))
    else $error("input stalled without a held item");

  a_push_into_full: assert property (@(posedge clk) disable iff (rst)
    (q_push && !take) |-> !q_status.full)
    else $error("front pushed into a full queue");

endmodule

`default_nettype wire
